>>> hdl/sstf_pkg.sv
// ----------------------------------------------------------------------------
// SSTF scheduler package
// Shared constants and types for the shortest-seek-time-first scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

    // Default geometry of the request table.
    localparam int MaxRequests  = 64;
    localparam int CylinderBits = 16;

    // Fixed field widths of the stream payloads.
    localparam int InCylW   = 16;
    localparam int OutCylW  = 16;
    localparam int OutDistW = 16;
    localparam int TotalW   = 22;
    localparam int InDataW  = 16;
    localparam int OutDataW = 56;

    // Saturation limit of the running seek total.
    localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

    // Request kinds carried on the input tuser bit.
    localparam logic ModeLoad = 1'b0;
    localparam logic ModeRun  = 1'b1;

    // Control from the sequencer to the nearest-entry tracker.
    typedef struct packed {
        logic clr;
        logic vld;
    } t_scan_ctl;

endpackage

>>> hdl/sstf_req_mem.sv
// ----------------------------------------------------------------------------
// SSTF request memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sstf_req_mem #(
    parameter int Depth = 64,
    parameter int Width = 17,
    parameter int AddrW = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [Width-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AddrW-1:0] i_raddr,
    output logic [Width-1:0] o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/sstf_nearest.sv
// ----------------------------------------------------------------------------
// SSTF nearest-entry tracker
// Compares each entry read from the memory with the best one seen so far.
// ----------------------------------------------------------------------------
module sstf_nearest #(
    parameter int CylW = 16,
    parameter int IdxW = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sstf_pkg::t_scan_ctl  i_ctl,
    input  logic [IdxW-1:0]      i_idx,
    input  logic                 i_served,
    input  logic [CylW-1:0]      i_cyl,
    input  logic [CylW-1:0]      i_head,
    output logic [IdxW-1:0]      o_best_idx,
    output logic [CylW-1:0]      o_best_cyl,
    output logic [CylW-1:0]      o_best_dist
);

    import sstf_pkg::*;

    logic            r_found;
    logic [IdxW-1:0] r_best_idx;
    logic [CylW-1:0] r_best_cyl;
    logic [CylW-1:0] r_best_dist;
    logic [CylW-1:0] w_dist;
    logic            w_take;

    assign w_dist = (i_head > i_cyl) ? (i_head - i_cyl) : (i_cyl - i_head);
    // Strictly closer only, so the earliest loaded entry wins a tie.
    assign w_take = i_ctl.vld && !i_served && (!r_found || (w_dist < r_best_dist));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clr) begin
            r_found <= 1'b0;
        end else if (w_take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_best_idx  <= i_idx;
            r_best_cyl  <= i_cyl;
            r_best_dist <= w_dist;
        end
    end

    assign o_best_idx  = r_best_idx;
    assign o_best_cyl  = r_best_cyl;
    assign o_best_dist = r_best_dist;

endmodule

>>> hdl/sstf_disk_scheduler_unit.sv
// ----------------------------------------------------------------------------
// SSTF disk scheduler unit
// Collects cylinder requests and serves them in shortest-seek-first order.
// ----------------------------------------------------------------------------
// Each result of a run needs its own sweep that reads all n stored
// requests, then the registered read data and a step that marks the served
// entry; the single read port of the request memory sets this. The mark step
// waits while the output register is full. Requests are taken only while idle.
// Reset: synchronous, active low; clears the count, flags, head and total.
// The request memory has no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
//
// Operation. A request whose tuser bit is clear is a load: its cylinder is
// written to the next free memory entry together with a clear served bit.
// Once the table holds MaxReq entries further loads are dropped and the
// overflow flag is set. A request whose tuser bit is set is a run: its
// cylinder becomes the head position. For every stored entry the sequencer
// then sweeps the memory, the tracker keeps the unserved entry nearest the
// head, and the winner is written back with its served bit set and put into
// the output register. After the last result the table and the overflow
// flag are cleared. A run on an empty table only clears the flag.
//
// The write-back of the served bit happens in its own cycle before the next
// sweep starts reading, so a sweep never reads an entry that is being
// written in the same cycle and no forwarding path is needed.
module sstf_disk_scheduler_unit #(
    parameter int MaxReq = sstf_pkg::MaxRequests,
    parameter int CylW   = sstf_pkg::CylinderBits
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input requests.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [sstf_pkg::InDataW-1:0]  s_axis_tdata,   // [15:0] cylinder
    input  logic                          s_axis_tuser,   // [0] mode (0 load, 1 run)
    // Served requests.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [sstf_pkg::OutDataW-1:0] m_axis_tdata,   // [15:0] served_cylinder,
                                                          // [31:16] seek_distance,
                                                          // [53:32] seek_total,
                                                          // [55:54] zero
    output logic                          m_axis_tlast,   // last_served
    output logic                          m_axis_tuser    // [0] overflowed
);

    import sstf_pkg::*;

    localparam int CntW = $clog2(MaxReq + 1);
    localparam int IdxW = (MaxReq > 1) ? $clog2(MaxReq) : 1;
    localparam int SumW = ((CylW > TotalW) ? CylW : TotalW) + 1;
    localparam int PadW = OutDataW - OutCylW - OutDistW - TotalW;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_MARK = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [CntW-1:0] r_count, n_count;
    logic            r_overflow, n_overflow;
    logic [CylW-1:0] r_head, n_head;
    logic [TotalW-1:0] r_total, n_total;
    logic [IdxW-1:0] r_picks, n_picks;

    // Sweep read pipeline.
    logic [IdxW-1:0] r_issue, n_issue;
    logic            r_issue_done, n_issue_done;
    logic            r_rd_vld;
    logic            r_rd_last;
    logic [IdxW-1:0] r_rd_idx;

    // Output register.
    logic                r_out_vld, n_out_vld;
    logic [OutCylW-1:0]  r_out_cyl;
    logic [OutDistW-1:0] r_out_dist;
    logic [TotalW-1:0]   r_out_total;
    logic                r_out_last;
    logic                r_out_ovf;

    // Memory ports.
    logic            w_we;
    logic [IdxW-1:0] w_waddr;
    logic [CylW:0]   w_wdata;
    logic            w_re;
    logic [CylW:0]   w_rdata;

    t_scan_ctl       w_ctl;
    logic [IdxW-1:0] w_best_idx;
    logic [CylW-1:0] w_best_cyl;
    logic [CylW-1:0] w_best_dist;

    logic            w_in_acc;
    logic [31:0]     w_in_cyl32;
    logic [CylW-1:0] w_in_cyl;
    logic            w_full;
    logic [CntW-1:0] w_cnt_m1;
    logic [IdxW-1:0] w_last_idx;
    logic            w_issue_last;
    logic            w_out_free;
    logic            w_emit;
    logic            w_pick_last;
    logic [SumW-1:0] w_sum;
    logic [TotalW-1:0] w_total_sat;
    logic [31:0]     w_best_cyl32;
    logic [31:0]     w_best_dist32;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // Only the low CylW bits of the cylinder field are used.
    assign w_in_cyl32 = 32'(s_axis_tdata[InCylW-1:0]);
    assign w_in_cyl   = w_in_cyl32[CylW-1:0];

    assign w_full       = (r_count == CntW'(MaxReq));
    assign w_cnt_m1     = r_count - 1'b1;
    assign w_last_idx   = w_cnt_m1[IdxW-1:0];
    assign w_issue_last = (r_issue == w_last_idx);
    assign w_pick_last  = (r_picks == w_last_idx);

    assign w_out_free = !r_out_vld || m_axis_tready;
    assign w_emit     = (r_state == ST_MARK) && w_out_free;

    // Running total saturates at the top of its field.
    assign w_sum       = SumW'(r_total) + SumW'(w_best_dist);
    assign w_total_sat = (w_sum > SumW'(TotalMax)) ? TotalMax : w_sum[TotalW-1:0];

    assign w_best_cyl32  = 32'(w_best_cyl);
    assign w_best_dist32 = 32'(w_best_dist);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_overflow   = r_overflow;
        n_head       = r_head;
        n_total      = r_total;
        n_picks      = r_picks;
        n_issue      = r_issue;
        n_issue_done = r_issue_done;
        n_out_vld    = r_out_vld && !m_axis_tready;
        w_we         = 1'b0;
        w_waddr      = r_count[IdxW-1:0];
        w_wdata      = {1'b0, w_in_cyl};
        w_re         = 1'b0;
        w_ctl.clr    = 1'b0;
        w_ctl.vld    = r_rd_vld;

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (s_axis_tuser == ModeLoad) begin
                        if (w_full) begin
                            n_overflow = 1'b1;
                        end else begin
                            w_we    = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end else if (r_count == '0) begin
                        n_overflow = 1'b0;
                    end else begin
                        n_head       = w_in_cyl;
                        n_total      = '0;
                        n_picks      = '0;
                        n_issue      = '0;
                        n_issue_done = 1'b0;
                        w_ctl.clr    = 1'b1;
                        n_state      = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (!r_issue_done) begin
                    w_re = 1'b1;
                    if (w_issue_last) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_issue = r_issue + 1'b1;
                    end
                end
                if (r_rd_vld && r_rd_last) begin
                    n_state = ST_MARK;
                end
            end
            ST_MARK: begin
                if (w_out_free) begin
                    w_we      = 1'b1;
                    w_waddr   = w_best_idx;
                    w_wdata   = {1'b1, w_best_cyl};
                    n_out_vld = 1'b1;
                    n_head    = w_best_cyl;
                    n_total   = w_total_sat;
                    if (w_pick_last) begin
                        n_count    = '0;
                        n_overflow = 1'b0;
                        n_picks    = '0;
                        n_state    = ST_IDLE;
                    end else begin
                        n_picks      = r_picks + 1'b1;
                        n_issue      = '0;
                        n_issue_done = 1'b0;
                        w_ctl.clr    = 1'b1;
                        n_state      = ST_SCAN;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_overflow   <= 1'b0;
            r_head       <= '0;
            r_total      <= '0;
            r_picks      <= '0;
            r_issue      <= '0;
            r_issue_done <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_overflow   <= n_overflow;
            r_head       <= n_head;
            r_total      <= n_total;
            r_picks      <= n_picks;
            r_issue      <= n_issue;
            r_issue_done <= n_issue_done;
            r_rd_vld     <= w_re;
            r_out_vld    <= n_out_vld;
        end
    end

    // Sideband that travels with each memory read.
    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rd_idx  <= r_issue;
            r_rd_last <= w_issue_last;
        end
    end

    // Result payload, loaded when the served entry is marked.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_cyl   <= w_best_cyl32[OutCylW-1:0];
            r_out_dist  <= w_best_dist32[OutDistW-1:0];
            r_out_total <= w_total_sat;
            r_out_last  <= w_pick_last;
            r_out_ovf   <= r_overflow;
        end
    end

    sstf_req_mem #(
        .Depth (MaxReq),
        .Width (CylW + 1),
        .AddrW (IdxW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_issue),
        .o_rdata (w_rdata)
    );

    sstf_nearest #(
        .CylW (CylW),
        .IdxW (IdxW)
    ) u_nearest (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_idx       (r_rd_idx),
        .i_served    (w_rdata[CylW]),
        .i_cyl       (w_rdata[CylW-1:0]),
        .i_head      (r_head),
        .o_best_idx  (w_best_idx),
        .o_best_cyl  (w_best_cyl),
        .o_best_dist (w_best_dist)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {PadW'(0), r_out_total, r_out_dist, r_out_cyl};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_ovf;

endmodule
